>>> rtl/core/rhsv_pkg.sv
package rhsv_pkg;

    localparam int unsigned HUE_FRAC_BITS_DEFAULT = 6;
    localparam int unsigned CHAN_W                = 8;
    localparam int unsigned HUE_W                 = 15;
    localparam int unsigned SAT_W                 = 8;
    localparam int unsigned S_TDATA_W             = 24;
    localparam int unsigned M_TDATA_W             = 32;

    // per-pixel status that rides along the divider row
    typedef struct packed {
        logic neg;
        logic grey;
        logic black;
    } rhsv_flags_t;

endpackage

>>> rtl/core/rhsv_front.sv
module rhsv_front #(
    parameter int unsigned HUE_FRAC_BITS = rhsv_pkg::HUE_FRAC_BITS_DEFAULT,
    parameter int unsigned WORD_W        = 12,
    parameter int unsigned BASE_W        = 15
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [rhsv_pkg::CHAN_W-1:0]         red,
    input  logic [rhsv_pkg::CHAN_W-1:0]         green,
    input  logic [rhsv_pkg::CHAN_W-1:0]         blue,
    output logic                                out_valid,
    output rhsv_pkg::rhsv_flags_t               out_flags,
    output logic [BASE_W-1:0]                   out_base,
    output logic [rhsv_pkg::CHAN_W-1:0]         out_value,
    output logic [rhsv_pkg::CHAN_W-1:0]         out_delta,
    output logic [rhsv_pkg::CHAN_W-1:0]         out_hue_rem,
    output logic [WORD_W-1:0]                   out_hue_word,
    output logic [rhsv_pkg::CHAN_W-1:0]         out_sat_rem,
    output logic [WORD_W-1:0]                   out_sat_word
);

    localparam int unsigned CW         = rhsv_pkg::CHAN_W;
    localparam int unsigned NUM_W      = WORD_W + CW;
    localparam int unsigned HUE_SIXTY  = 60 * (2 ** HUE_FRAC_BITS);
    localparam int unsigned HUE_FULL   = 6 * HUE_SIXTY;

    logic                   valid_reg;
    rhsv_pkg::rhsv_flags_t  flags_reg, flags_next;
    logic [BASE_W-1:0]      base_reg, base_next;
    logic [CW-1:0]          value_reg, value_next;
    logic [CW-1:0]          delta_reg, delta_next;
    logic [NUM_W-1:0]       hue_num_reg, hue_num_next;
    logic [NUM_W-1:0]       sat_num_reg, sat_num_next;

    logic          red_max, green_max;
    logic [CW-1:0] lo, pos_term, neg_term, mag;

    always_comb begin
        red_max   = (red >= green) && (red >= blue);
        green_max = !red_max && (green >= blue);
        if (red_max) begin
            value_next = red;
            pos_term   = green;
            neg_term   = blue;
        end else if (green_max) begin
            value_next = green;
            pos_term   = blue;
            neg_term   = red;
        end else begin
            value_next = blue;
            pos_term   = red;
            neg_term   = green;
        end
        lo = red;
        if (green < lo) begin
            lo = green;
        end
        if (blue < lo) begin
            lo = blue;
        end
        delta_next       = value_next - lo;
        flags_next.neg   = pos_term < neg_term;
        flags_next.grey  = delta_next == '0;
        flags_next.black = value_next == '0;
        mag = flags_next.neg ? (neg_term - pos_term) : (pos_term - neg_term);
        if (red_max) begin
            base_next = flags_next.neg ? BASE_W'(HUE_FULL) : '0;
        end else if (green_max) begin
            base_next = BASE_W'(2 * HUE_SIXTY);
        end else begin
            base_next = BASE_W'(4 * HUE_SIXTY);
        end
        hue_num_next = NUM_W'(HUE_SIXTY) * NUM_W'(mag);
        sat_num_next = (NUM_W'(delta_next) << CW) - NUM_W'(delta_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            flags_reg   <= flags_next;
            base_reg    <= base_next;
            value_reg   <= value_next;
            delta_reg   <= delta_next;
            hue_num_reg <= hue_num_next;
            sat_num_reg <= sat_num_next;
        end
    end

    assign out_valid    = valid_reg;
    assign out_flags    = flags_reg;
    assign out_base     = base_reg;
    assign out_value    = value_reg;
    assign out_delta    = delta_reg;
    assign out_hue_rem  = hue_num_reg[NUM_W-1:WORD_W];
    assign out_hue_word = hue_num_reg[WORD_W-1:0];
    assign out_sat_rem  = sat_num_reg[NUM_W-1:WORD_W];
    assign out_sat_word = sat_num_reg[WORD_W-1:0];

endmodule

>>> rtl/core/rhsv_cell.sv
module rhsv_cell #(
    parameter int unsigned WORD_W = 12,
    parameter int unsigned BASE_W = 15
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  rhsv_pkg::rhsv_flags_t               in_flags,
    input  logic [BASE_W-1:0]                   in_base,
    input  logic [rhsv_pkg::CHAN_W-1:0]         in_value,
    input  logic [rhsv_pkg::CHAN_W-1:0]         in_delta,
    input  logic [rhsv_pkg::CHAN_W-1:0]         in_hue_rem,
    input  logic [WORD_W-1:0]                   in_hue_word,
    input  logic [rhsv_pkg::CHAN_W-1:0]         in_sat_rem,
    input  logic [WORD_W-1:0]                   in_sat_word,
    output logic                                out_valid,
    output rhsv_pkg::rhsv_flags_t               out_flags,
    output logic [BASE_W-1:0]                   out_base,
    output logic [rhsv_pkg::CHAN_W-1:0]         out_value,
    output logic [rhsv_pkg::CHAN_W-1:0]         out_delta,
    output logic [rhsv_pkg::CHAN_W-1:0]         out_hue_rem,
    output logic [WORD_W-1:0]                   out_hue_word,
    output logic [rhsv_pkg::CHAN_W-1:0]         out_sat_rem,
    output logic [WORD_W-1:0]                   out_sat_word
);

    localparam int unsigned CW = rhsv_pkg::CHAN_W;

    logic                   valid_reg;
    rhsv_pkg::rhsv_flags_t  flags_reg;
    logic [BASE_W-1:0]      base_reg;
    logic [CW-1:0]          value_reg;
    logic [CW-1:0]          delta_reg;
    logic [CW-1:0]          hue_rem_reg, hue_rem_next;
    logic [WORD_W-1:0]      hue_word_reg, hue_word_next;
    logic [CW-1:0]          sat_rem_reg, sat_rem_next;
    logic [WORD_W-1:0]      sat_word_reg, sat_word_next;

    logic [CW:0] hue_trial, hue_diff, sat_trial, sat_diff;
    logic        hue_ge, sat_ge;

    // one restoring step per division: one quotient bit per cell
    always_comb begin
        hue_trial     = {in_hue_rem, in_hue_word[WORD_W-1]};
        hue_diff      = hue_trial - {1'b0, in_delta};
        hue_ge        = hue_trial >= {1'b0, in_delta};
        hue_rem_next  = hue_ge ? hue_diff[CW-1:0] : hue_trial[CW-1:0];
        hue_word_next = {in_hue_word[WORD_W-2:0], hue_ge};

        sat_trial     = {in_sat_rem, in_sat_word[WORD_W-1]};
        sat_diff      = sat_trial - {1'b0, in_value};
        sat_ge        = sat_trial >= {1'b0, in_value};
        sat_rem_next  = sat_ge ? sat_diff[CW-1:0] : sat_trial[CW-1:0];
        sat_word_next = {in_sat_word[WORD_W-2:0], sat_ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            flags_reg    <= in_flags;
            base_reg     <= in_base;
            value_reg    <= in_value;
            delta_reg    <= in_delta;
            hue_rem_reg  <= hue_rem_next;
            hue_word_reg <= hue_word_next;
            sat_rem_reg  <= sat_rem_next;
            sat_word_reg <= sat_word_next;
        end
    end

    assign out_valid    = valid_reg;
    assign out_flags    = flags_reg;
    assign out_base     = base_reg;
    assign out_value    = value_reg;
    assign out_delta    = delta_reg;
    assign out_hue_rem  = hue_rem_reg;
    assign out_hue_word = hue_word_reg;
    assign out_sat_rem  = sat_rem_reg;
    assign out_sat_word = sat_word_reg;

endmodule

>>> rtl/core/rhsv_back.sv
module rhsv_back #(
    parameter int unsigned HUE_FRAC_BITS = rhsv_pkg::HUE_FRAC_BITS_DEFAULT,
    parameter int unsigned WORD_W        = 12,
    parameter int unsigned BASE_W        = 15
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  rhsv_pkg::rhsv_flags_t               in_flags,
    input  logic [BASE_W-1:0]                   in_base,
    input  logic [rhsv_pkg::CHAN_W-1:0]         in_value,
    input  logic [WORD_W-1:0]                   in_hue_quot,
    input  logic [WORD_W-1:0]                   in_sat_quot,
    output logic                                out_valid,
    output logic [rhsv_pkg::M_TDATA_W-1:0]      out_data
);

    localparam int unsigned HUE_W     = rhsv_pkg::HUE_W;
    localparam int unsigned SAT_W     = rhsv_pkg::SAT_W;
    localparam int unsigned CW        = rhsv_pkg::CHAN_W;
    localparam int unsigned HUE_SIXTY = 60 * (2 ** HUE_FRAC_BITS);
    localparam int unsigned HUE_FULL  = 6 * HUE_SIXTY;
    localparam int unsigned HCW       = (BASE_W > HUE_W) ? BASE_W : HUE_W;
    localparam int unsigned PAD_W     = rhsv_pkg::M_TDATA_W - HUE_W - SAT_W - CW;

    logic                  valid_reg;
    logic [HUE_W-1:0]      hue_reg, hue_next;
    logic [SAT_W-1:0]      sat_reg, sat_next;
    logic [CW-1:0]         value_reg;

    logic [BASE_W-1:0] hue_sum, hue_wrap;
    logic [HCW-1:0]    hue_wide;

    always_comb begin
        hue_sum = in_flags.neg ? (in_base - BASE_W'(in_hue_quot))
                               : (in_base + BASE_W'(in_hue_quot));
        // a full turn wraps to zero
        hue_wrap = (hue_sum >= BASE_W'(HUE_FULL)) ? (hue_sum - BASE_W'(HUE_FULL)) : hue_sum;
        hue_wide = HCW'(hue_wrap);
        hue_next = in_flags.grey ? '0 : hue_wide[HUE_W-1:0];
        sat_next = in_flags.black ? '0 : in_sat_quot[SAT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            value_reg <= in_value;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = {{PAD_W{1'b0}}, value_reg, sat_reg, hue_reg};

endmodule

>>> rtl/core/rgb_to_hsv_unit.sv
// rgb to hsv conversion, one pixel of 8-bit channels per request
//
// input stream s_*: tdata carries red [7:0], green [15:8], blue [23:16]
// output stream m_*: tdata carries hue [14:0] in degrees scaled by
// 2^HUE_FRAC_BITS, saturation [22:15] (255 is full), value [30:23]
//
// a front stage finds max, min and the hue branch, then a row of identical
// divider cells resolves one quotient bit per cell for both the hue and the
// saturation division, and a final stage adds the branch offset
// a pixel passes the front register, WORD_W cells and the final register, where
// WORD_W is the larger of 8 and the bit count of 60 * 2^HUE_FRAC_BITS (one cell per bit)
// throughput: one pixel per cycle, except while m_tready stalls the pipeline
//
// the whole pipeline advances when the output register is empty or taken;
// while m_tready is low with a result waiting, every stage holds and
// s_tready drops, so no result is lost
// reset empties the pipeline; nothing else is kept between pixels
module rgb_to_hsv_unit #(
    parameter int unsigned HUE_FRAC_BITS = rhsv_pkg::HUE_FRAC_BITS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rhsv_pkg::S_TDATA_W-1:0]     s_tdata,   // red, green, blue
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [rhsv_pkg::M_TDATA_W-1:0]     m_tdata    // hue, saturation, value, pad
);

    localparam int unsigned CW        = rhsv_pkg::CHAN_W;
    localparam int unsigned HUE_SIXTY = 60 * (2 ** HUE_FRAC_BITS);
    localparam int unsigned QH_W      = $clog2(HUE_SIXTY + 1);
    localparam int unsigned WORD_W    = (QH_W > CW) ? QH_W : CW;
    localparam int unsigned BASE_W    = $clog2(6 * HUE_SIXTY + 1);

    logic en;

    logic                  st_valid [0:WORD_W];
    rhsv_pkg::rhsv_flags_t st_flags [0:WORD_W];
    logic [BASE_W-1:0]     st_base  [0:WORD_W];
    logic [CW-1:0]         st_value [0:WORD_W];
    logic [CW-1:0]         st_delta [0:WORD_W];
    logic [CW-1:0]         st_hrem  [0:WORD_W];
    logic [WORD_W-1:0]     st_hword [0:WORD_W];
    logic [CW-1:0]         st_srem  [0:WORD_W];
    logic [WORD_W-1:0]     st_sword [0:WORD_W];

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    rhsv_front #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS),
        .WORD_W        (WORD_W),
        .BASE_W        (BASE_W)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (s_tvalid),
        .red          (s_tdata[CW-1:0]),
        .green        (s_tdata[2*CW-1:CW]),
        .blue         (s_tdata[3*CW-1:2*CW]),
        .out_valid    (st_valid[0]),
        .out_flags    (st_flags[0]),
        .out_base     (st_base[0]),
        .out_value    (st_value[0]),
        .out_delta    (st_delta[0]),
        .out_hue_rem  (st_hrem[0]),
        .out_hue_word (st_hword[0]),
        .out_sat_rem  (st_srem[0]),
        .out_sat_word (st_sword[0])
    );

    for (genvar i = 0; i < WORD_W; i++) begin : g_cell
        rhsv_cell #(
            .WORD_W (WORD_W),
            .BASE_W (BASE_W)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .en           (en),
            .in_valid     (st_valid[i]),
            .in_flags     (st_flags[i]),
            .in_base      (st_base[i]),
            .in_value     (st_value[i]),
            .in_delta     (st_delta[i]),
            .in_hue_rem   (st_hrem[i]),
            .in_hue_word  (st_hword[i]),
            .in_sat_rem   (st_srem[i]),
            .in_sat_word  (st_sword[i]),
            .out_valid    (st_valid[i+1]),
            .out_flags    (st_flags[i+1]),
            .out_base     (st_base[i+1]),
            .out_value    (st_value[i+1]),
            .out_delta    (st_delta[i+1]),
            .out_hue_rem  (st_hrem[i+1]),
            .out_hue_word (st_hword[i+1]),
            .out_sat_rem  (st_srem[i+1]),
            .out_sat_word (st_sword[i+1])
        );
    end

    rhsv_back #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS),
        .WORD_W        (WORD_W),
        .BASE_W        (BASE_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (st_valid[WORD_W]),
        .in_flags    (st_flags[WORD_W]),
        .in_base     (st_base[WORD_W]),
        .in_value    (st_value[WORD_W]),
        .in_hue_quot (st_hword[WORD_W]),
        .in_sat_quot (st_sword[WORD_W]),
        .out_valid   (m_tvalid),
        .out_data    (m_tdata)
    );

endmodule
